>>> sv/pcrm_pkg.sv
// Shared types and codes for the per-core ring mailbox.
package pcrm_pkg;

    typedef enum logic [2:0] {
        ACT_INIT  = 3'd0,
        ACT_BIND  = 3'd1,
        ACT_MARK  = 3'd2,
        ACT_QUERY = 3'd3,
        ACT_SEND  = 3'd4,
        ACT_RECV  = 3'd5,
        ACT_TAKE  = 3'd6,
        ACT_PUT   = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_STATE = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_BUSY      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_LOOKUP,
        FSM_EXEC,
        FSM_FINISH
    } fsm_t;

    typedef struct packed {
        action_t     action;
        logic [7:0]  core;
        logic [63:0] message;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic        ready_res;
        logic [63:0] message_out;
    } out_item_t;

endpackage

>>> sv/pcrm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pcrm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/per_core_ring_mailbox.sv
// Top level of the per-core ring mailbox: control FSM, channel table and message store.
//
//  Channel  | Ports                          | Payload
//  ---------+--------------------------------+-----------------------------------
//  request  | s_valid, s_ready, s_data       | action, core, message
//  response | m_valid, m_ready, m_data       | status, ready_res, message_out
//
// Each item passes through the states idle, lookup, execute and finish: the accepting
// edge registers the channel table read, a lookup state follows, execute writes back the
// table where the action changes it and makes at most one message store access, and finish
// loads the response register. One item is in flight at a time; the next is accepted while a response waits.
// A stalled response holds the FSM in its final step until the output register frees.
// Reset and the init action clear the per-channel valid bits; no clearing pass is run.
module per_core_ring_mailbox #(
    parameter int CORES      = 8,
    parameter int RING_DEPTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  pcrm_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output pcrm_pkg::out_item_t  m_data
);

    localparam int CW = $clog2(CORES);
    localparam int PW = $clog2(RING_DEPTH);
    localparam int MSG_DEPTH = 2 * CORES * RING_DEPTH;
    localparam int AW = $clog2(MSG_DEPTH);

    typedef struct packed {
        logic          bound;
        logic [PW-1:0] out_head;
        logic [PW-1:0] out_tail;
        logic [PW-1:0] in_head;
        logic [PW-1:0] in_tail;
    } ctl_t;

    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
        return (p == PW'(RING_DEPTH - 1)) ? '0 : PW'(p + PW'(1));
    endfunction

    pcrm_pkg::fsm_t      state_reg, state_next;
    pcrm_pkg::in_item_t  item_reg;
    logic [CORES-1:0]    valid_reg;
    pcrm_pkg::status_t   res_status_reg, res_status_next;
    logic                res_ready_reg, res_ready_next;
    logic                res_pop_reg, res_pop_next;
    logic                m_valid_reg;
    pcrm_pkg::out_item_t m_data_reg;

    logic              accept;
    logic              out_load;
    logic [CW-1:0]     ch;
    logic              in_range;
    logic              exec;
    ctl_t              ctl_rd, ctl_cur, ctl_new;
    logic              ctl_we;
    logic              msg_we, msg_re;
    logic              ring_in;
    logic [PW-1:0]     msg_ptr;
    logic [AW-1:0]     msg_addr;
    logic [63:0]       msg_rdata;
    logic [PW-1:0]     head, tail, nxt;

    assign accept   = s_valid && s_ready;
    assign out_load = (state_reg == pcrm_pkg::FSM_FINISH) && (!m_valid_reg || m_ready);
    assign ch       = item_reg.core[CW-1:0];
    assign in_range = item_reg.core < 8'(CORES);
    assign exec     = (state_reg == pcrm_pkg::FSM_EXEC);

    pcrm_ram #(
        .WIDTH ($bits(ctl_t)),
        .DEPTH (CORES)
    ) u_ctl_ram (
        .aclk  (aclk),
        .we    (ctl_we),
        .waddr (ch),
        .wdata (ctl_new),
        .re    (accept),
        .raddr (s_data.core[CW-1:0]),
        .rdata (ctl_rd)
    );

    // Message slots: ring select on top, then channel, then slot.
    assign msg_addr = AW'(AW'(ring_in) * AW'(CORES * RING_DEPTH)
                    + AW'(ch) * AW'(RING_DEPTH) + AW'(msg_ptr));

    pcrm_ram #(
        .WIDTH (64),
        .DEPTH (MSG_DEPTH)
    ) u_msg_ram (
        .aclk  (aclk),
        .we    (msg_we),
        .waddr (msg_addr),
        .wdata (item_reg.message),
        .re    (msg_re),
        .raddr (msg_addr),
        .rdata (msg_rdata)
    );

    // A channel never written since init reads as all zero.
    assign ctl_cur = valid_reg[ch] ? ctl_rd : '0;

    always_comb begin
        ctl_new         = ctl_cur;
        ctl_we          = 1'b0;
        msg_we          = 1'b0;
        msg_re          = 1'b0;
        res_status_next = pcrm_pkg::ST_OK;
        res_ready_next  = 1'b0;
        res_pop_next    = 1'b0;
        ring_in         = (item_reg.action == pcrm_pkg::ACT_PUT)
                       || (item_reg.action == pcrm_pkg::ACT_RECV);
        head            = ring_in ? ctl_cur.in_head : ctl_cur.out_head;
        tail            = ring_in ? ctl_cur.in_tail : ctl_cur.out_tail;
        msg_ptr         = tail;
        nxt             = ring_next(tail);
        unique case (item_reg.action)
            pcrm_pkg::ACT_INIT: begin
            end
            pcrm_pkg::ACT_BIND: begin
                if (item_reg.core != 8'd0) begin
                    if (in_range && ctl_cur.out_head == '0 && ctl_cur.in_head == '0) begin
                        ctl_new.bound = 1'b1;
                        ctl_we        = exec;
                    end else begin
                        res_status_next = pcrm_pkg::ST_BAD_STATE;
                    end
                end
            end
            pcrm_pkg::ACT_MARK: begin
                if (in_range) begin
                    ctl_new.bound = 1'b1;
                    ctl_we        = exec;
                end else begin
                    res_status_next = pcrm_pkg::ST_NOT_FOUND;
                end
            end
            pcrm_pkg::ACT_QUERY: begin
                if (in_range) begin
                    res_ready_next = ctl_cur.bound;
                end else begin
                    res_status_next = pcrm_pkg::ST_NOT_FOUND;
                end
            end
            pcrm_pkg::ACT_SEND, pcrm_pkg::ACT_PUT: begin
                msg_ptr = head;
                nxt     = ring_next(head);
                if (!in_range || !ctl_cur.bound) begin
                    res_status_next = pcrm_pkg::ST_NOT_FOUND;
                end else if (nxt == tail) begin
                    res_status_next = pcrm_pkg::ST_BUSY;
                end else begin
                    msg_we = exec;
                    ctl_we = exec;
                    if (ring_in) begin
                        ctl_new.in_head = nxt;
                    end else begin
                        ctl_new.out_head = nxt;
                    end
                end
            end
            pcrm_pkg::ACT_RECV, pcrm_pkg::ACT_TAKE: begin
                if (!in_range || !ctl_cur.bound || head == tail) begin
                    res_status_next = pcrm_pkg::ST_NOT_FOUND;
                end else begin
                    msg_re       = exec;
                    ctl_we       = exec;
                    res_pop_next = 1'b1;
                    if (ring_in) begin
                        ctl_new.in_tail = nxt;
                    end else begin
                        ctl_new.out_tail = nxt;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pcrm_pkg::FSM_IDLE: begin
                if (s_valid) begin
                    state_next = pcrm_pkg::FSM_LOOKUP;
                end
            end
            pcrm_pkg::FSM_LOOKUP: begin
                state_next = pcrm_pkg::FSM_EXEC;
            end
            pcrm_pkg::FSM_EXEC: begin
                state_next = pcrm_pkg::FSM_FINISH;
            end
            pcrm_pkg::FSM_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = pcrm_pkg::FSM_IDLE;
                end
            end
            default: begin
                state_next = pcrm_pkg::FSM_IDLE;
            end
        endcase
    end

    // Handshake outputs.
    always_comb begin
        s_ready = (state_reg == pcrm_pkg::FSM_IDLE);
        m_valid = m_valid_reg;
        m_data  = m_data_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pcrm_pkg::FSM_IDLE;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (exec && item_reg.action == pcrm_pkg::ACT_INIT) begin
                valid_reg <= '0;
            end else if (ctl_we) begin
                valid_reg[ch] <= 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_data;
        end
        if (exec) begin
            res_status_reg <= res_status_next;
            res_ready_reg  <= res_ready_next;
            res_pop_reg    <= res_pop_next;
        end
        if (out_load) begin
            m_data_reg.status      <= res_status_reg;
            m_data_reg.ready_res   <= res_ready_reg;
            m_data_reg.message_out <= res_pop_reg ? msg_rdata : 64'd0;
        end
    end

    // A response appears only as the last step of an item.
    a_resp_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == pcrm_pkg::FSM_FINISH)
        else $error("response raised outside the finish step");

    // The table is only written, and the store only written or read, while an item executes.
    a_write_in_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl_we || msg_we || msg_re) |-> exec)
        else $error("memory access outside the execute step");

    // A full ring can only be reported for a push.
    a_busy_push_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && res_status_reg == pcrm_pkg::ST_BUSY)
        |-> (item_reg.action == pcrm_pkg::ACT_SEND || item_reg.action == pcrm_pkg::ACT_PUT))
        else $error("busy status on an action that does not push");

    // A popped message always comes with an ok status.
    a_pop_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec && res_pop_next) |-> res_status_next == pcrm_pkg::ST_OK)
        else $error("pop flagged with a failing status");

    // No item is accepted while one is still in flight.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == pcrm_pkg::FSM_LOOKUP && !s_ready))
        else $error("accept did not start a lookup");

endmodule
